// ===== rtl/core/rle_pkg.sv =====
// Shared types, register indexes, effect codes and constant tables for the
// RGB LED effect engine. Used by rle_effect and the top level; no dependencies.
package rle_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_COLOUR     = 3'd1;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [2:0] REG_SPEED      = 3'd3;
  localparam logic [2:0] REG_ENABLE     = 3'd4;

  // Effect codes held in the mode register.
  localparam logic [3:0] MODE_BREATHE    = 4'd0;
  localparam logic [3:0] MODE_FADE3      = 4'd1;
  localparam logic [3:0] MODE_FADE7      = 4'd2;
  localparam logic [3:0] MODE_FADE_RG    = 4'd3;
  localparam logic [3:0] MODE_FADE_RB    = 4'd4;
  localparam logic [3:0] MODE_FADE_GB    = 4'd5;
  localparam logic [3:0] MODE_JUMP3      = 4'd6;
  localparam logic [3:0] MODE_JUMP7      = 4'd7;
  localparam logic [3:0] MODE_FLASH1     = 4'd8;
  localparam logic [3:0] MODE_FLASH7     = 4'd9;
  localparam logic [3:0] MODE_SOUND_FADE = 4'd10;

  typedef struct packed {
    logic       en;
    logic [2:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  // Levels and scale of one advance of the effect.
  typedef struct packed {
    logic       emit;
    logic [7:0] lvl_red;
    logic [7:0] lvl_green;
    logic [7:0] lvl_blue;
    logic [7:0] scale;
  } eff_out_t;

  typedef struct packed {
    logic [1:0] ch;
    logic       up;
  } fade_move_t;

  // Level of one channel for a colour index; index 7 is black.
  function automatic logic [7:0] colour_level(input logic [2:0] idx, input logic [1:0] ch);
    logic [2:0] rgb;
    case (idx)
      3'd0:    rgb = 3'b100;
      3'd1:    rgb = 3'b010;
      3'd2:    rgb = 3'b001;
      3'd3:    rgb = 3'b110;
      3'd4:    rgb = 3'b011;
      3'd5:    rgb = 3'b101;
      3'd6:    rgb = 3'b111;
      default: rgb = 3'b000;
    endcase
    case (ch)
      2'd0:    colour_level = rgb[2] ? 8'hff : 8'h00;
      2'd1:    colour_level = rgb[1] ? 8'hff : 8'h00;
      default: colour_level = rgb[0] ? 8'hff : 8'h00;
    endcase
  endfunction

  // Channel and direction of each step of the two-colour and seven-colour fades.
  function automatic fade_move_t fade_move(input logic [3:0] mode, input logic [2:0] ph);
    fade_move_t mv;
    mv = '{ch: 2'd0, up: 1'b0};
    case (mode)
      MODE_FADE7: begin
        case (ph)
          3'd0:    mv = '{ch: 2'd1, up: 1'b1};
          3'd1:    mv = '{ch: 2'd0, up: 1'b0};
          3'd2:    mv = '{ch: 2'd2, up: 1'b1};
          3'd3:    mv = '{ch: 2'd1, up: 1'b0};
          3'd4:    mv = '{ch: 2'd0, up: 1'b1};
          default: mv = '{ch: 2'd2, up: 1'b0};
        endcase
      end
      MODE_FADE_RG: begin
        case (ph[1:0])
          2'd0:    mv = '{ch: 2'd1, up: 1'b1};
          2'd1:    mv = '{ch: 2'd0, up: 1'b0};
          2'd2:    mv = '{ch: 2'd0, up: 1'b1};
          default: mv = '{ch: 2'd1, up: 1'b0};
        endcase
      end
      MODE_FADE_RB: begin
        case (ph[1:0])
          2'd0:    mv = '{ch: 2'd2, up: 1'b1};
          2'd1:    mv = '{ch: 2'd0, up: 1'b0};
          2'd2:    mv = '{ch: 2'd0, up: 1'b1};
          default: mv = '{ch: 2'd2, up: 1'b0};
        endcase
      end
      default: begin
        case (ph[1:0])
          2'd0:    mv = '{ch: 2'd2, up: 1'b1};
          2'd1:    mv = '{ch: 2'd1, up: 1'b0};
          2'd2:    mv = '{ch: 2'd1, up: 1'b1};
          default: mv = '{ch: 2'd2, up: 1'b0};
        endcase
      end
    endcase
    return mv;
  endfunction

endpackage

// ===== rtl/core/rle_effect.sv =====
// Configuration registers, effect state and the per-tick advance of the effect.
// Depends on rle_pkg.
module rle_effect (
  input  logic             clk,
  input  logic             rst,
  input  rle_pkg::cfg_wr_t cfg,
  input  logic             step,
  input  logic             mic,
  output rle_pkg::eff_out_t eff
);

  logic [3:0] effect_mode;
  logic [2:0] base_colour;
  logic [7:0] brightness;
  logic [3:0] speed;
  logic       effect_enable;

  logic [2:0] phase;
  logic [7:0] level_red, level_green, level_blue;
  logic [7:0] light_level;
  logic       dimming;
  logic [7:0] wait_count;
  logic       started;

  logic [2:0] phase_next;
  logic [7:0] lv [3];
  logic [7:0] light_level_next;
  logic       dimming_next;
  logic [7:0] wait_count_next;
  logic       started_next;
  logic       go;
  logic [7:0] scale;
  logic [8:0] nx;
  logic [3:0] w;
  logic [1:0] ci;
  logic [2:0] fade_len;
  logic [7:0] fade_step;
  logic [2:0] jump_len;
  rle_pkg::fade_move_t mv;

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] d);
    logic [8:0] s;
    s = {1'b0, v} + {1'b0, d};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] v, input logic [7:0] d);
    return (v > d) ? v - d : 8'd0;
  endfunction

  assign w = 4'd9 - ((speed > 4'd8) ? 4'd8 : speed);

  always_comb begin
    phase_next       = phase;
    lv[0]            = level_red;
    lv[1]            = level_green;
    lv[2]            = level_blue;
    light_level_next = light_level;
    dimming_next     = dimming;
    wait_count_next  = wait_count;
    started_next     = started;
    go               = 1'b0;
    scale            = brightness;
    nx               = 9'd0;
    ci               = 2'd0;
    mv               = '{ch: 2'd0, up: 1'b0};
    fade_len         = 3'd4;
    fade_step        = 8'd3;
    jump_len         = 3'd3;

    if (step && effect_enable && effect_mode <= rle_pkg::MODE_SOUND_FADE) begin
      if (!started) begin
        phase_next       = 3'd0;
        dimming_next     = 1'b0;
        lv[0]            = 8'd0;
        lv[1]            = 8'd0;
        lv[2]            = 8'd0;
        light_level_next = brightness;
        if (effect_mode == rle_pkg::MODE_FADE3 || effect_mode == rle_pkg::MODE_SOUND_FADE) begin
          lv[0] = 8'd10;
        end else if (effect_mode >= rle_pkg::MODE_FADE7 && effect_mode <= rle_pkg::MODE_FADE_RB) begin
          lv[0] = 8'd255;
        end else if (effect_mode == rle_pkg::MODE_FADE_GB) begin
          lv[1] = 8'd255;
        end
        started_next = 1'b1;
        go           = 1'b1;
      end else begin
        if (wait_count != 8'd0) begin
          wait_count_next = wait_count - 8'd1;
        end
        go = (wait_count_next == 8'd0);
      end
    end

    if (go) begin
      wait_count_next = {4'd0, w};
      case (effect_mode)
        rle_pkg::MODE_BREATHE: begin
          lv[0] = rle_pkg::colour_level(base_colour, 2'd0);
          lv[1] = rle_pkg::colour_level(base_colour, 2'd1);
          lv[2] = rle_pkg::colour_level(base_colour, 2'd2);
          scale = light_level_next;
          nx = {1'b0, light_level_next};
          if (!dimming_next) begin
            nx = nx + 9'd1;
            if (nx > {1'b0, brightness}) dimming_next = 1'b1;
          end
          if (dimming_next) begin
            if (nx != 9'd0) nx = nx - 9'd1;
            if (nx < 9'd5) dimming_next = 1'b0;
          end
          light_level_next = nx[8] ? 8'hff : nx[7:0];
        end
        rle_pkg::MODE_FADE3, rle_pkg::MODE_SOUND_FADE: begin
          if (effect_mode == rle_pkg::MODE_SOUND_FADE && mic) begin
            lv[0] = sat_add(lv[0], 8'd20);
            lv[1] = sat_add(lv[1], 8'd20);
            lv[2] = sat_add(lv[2], 8'd20);
          end else begin
            if (phase_next > 3'd5) phase_next = 3'd0;
            ci = phase_next[2:1];
            if (!phase_next[0]) begin
              lv[ci] = sat_add(lv[ci], 8'd3);
              if (lv[ci] >= 8'd250) phase_next = phase_next + 3'd1;
            end else begin
              lv[ci] = sat_sub(lv[ci], 8'd3);
              if (lv[ci] <= 8'd10) begin
                lv[ci]           = 8'd0;
                phase_next       = (phase_next == 3'd5) ? 3'd0 : phase_next + 3'd1;
                lv[phase_next[2:1]] = 8'd10;
                light_level_next = brightness;
              end
            end
          end
          scale = light_level_next;
        end
        rle_pkg::MODE_FADE7, rle_pkg::MODE_FADE_RG, rle_pkg::MODE_FADE_RB,
        rle_pkg::MODE_FADE_GB: begin
          if (effect_mode == rle_pkg::MODE_FADE7) begin
            fade_len  = 3'd6;
            fade_step = mic ? 8'd10 : 8'd3;
          end
          if (phase_next >= fade_len) phase_next = 3'd0;
          mv = rle_pkg::fade_move(effect_mode, phase_next);
          if (mv.up) begin
            lv[mv.ch] = sat_add(lv[mv.ch], fade_step);
            if (lv[mv.ch] >= 8'd254) phase_next = phase_next + 3'd1;
          end else begin
            lv[mv.ch] = sat_sub(lv[mv.ch], fade_step);
            if (lv[mv.ch] <= 8'd3) phase_next = phase_next + 3'd1;
          end
          if (phase_next >= fade_len) phase_next = 3'd0;
        end
        rle_pkg::MODE_JUMP3, rle_pkg::MODE_JUMP7: begin
          if (effect_mode == rle_pkg::MODE_JUMP7) jump_len = 3'd7;
          if (phase_next >= jump_len) phase_next = 3'd0;
          lv[0] = rle_pkg::colour_level(phase_next, 2'd0);
          lv[1] = rle_pkg::colour_level(phase_next, 2'd1);
          lv[2] = rle_pkg::colour_level(phase_next, 2'd2);
          phase_next = phase_next + 3'd1;
          if (phase_next >= jump_len) phase_next = 3'd0;
          wait_count_next = {w, 4'd0} - {4'd0, w};
        end
        default: begin
          // Both flashes alternate between the set brightness and dark on each advance.
          if (effect_mode == rle_pkg::MODE_FLASH1) begin
            lv[0] = rle_pkg::colour_level(base_colour, 2'd0);
            lv[1] = rle_pkg::colour_level(base_colour, 2'd1);
            lv[2] = rle_pkg::colour_level(base_colour, 2'd2);
          end else begin
            if (phase_next > 3'd6) phase_next = 3'd0;
            lv[0] = rle_pkg::colour_level(phase_next, 2'd0);
            lv[1] = rle_pkg::colour_level(phase_next, 2'd1);
            lv[2] = rle_pkg::colour_level(phase_next, 2'd2);
          end
          scale = light_level_next;
          if (light_level_next != 8'd0) begin
            light_level_next = 8'd0;
          end else begin
            light_level_next = brightness;
            if (effect_mode == rle_pkg::MODE_FLASH7) begin
              phase_next = (phase_next >= 3'd6) ? 3'd0 : phase_next + 3'd1;
            end
          end
          wait_count_next = {1'b0, w, 3'd0} + {3'd0, w, 1'b0};
        end
      endcase
    end
  end

  always_comb begin
    eff.emit      = go;
    eff.lvl_red   = lv[0];
    eff.lvl_green = lv[1];
    eff.lvl_blue  = lv[2];
    eff.scale     = scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= rle_pkg::MODE_BREATHE;
      base_colour   <= 3'd0;
      brightness    <= 8'd255;
      speed         <= 4'd0;
      effect_enable <= 1'b0;
      phase         <= 3'd0;
      level_red     <= 8'd0;
      level_green   <= 8'd0;
      level_blue    <= 8'd0;
      light_level   <= 8'd0;
      dimming       <= 1'b0;
      wait_count    <= 8'd0;
      started       <= 1'b0;
    end else if (cfg.en && cfg.index <= rle_pkg::REG_ENABLE) begin
      unique case (cfg.index)
        rle_pkg::REG_MODE:       effect_mode   <= cfg.data[3:0];
        rle_pkg::REG_COLOUR:     base_colour   <= cfg.data[2:0];
        rle_pkg::REG_BRIGHTNESS: brightness    <= cfg.data;
        rle_pkg::REG_SPEED:      speed         <= cfg.data[3:0];
        default:                 effect_enable <= cfg.data[0];
      endcase
      // A write to any of the five registers restarts the effect.
      started    <= 1'b0;
      wait_count <= 8'd0;
    end else begin
      phase       <= phase_next;
      level_red   <= lv[0];
      level_green <= lv[1];
      level_blue  <= lv[2];
      light_level <= light_level_next;
      dimming     <= dimming_next;
      wait_count  <= wait_count_next;
      started     <= started_next;
    end
  end

endmodule

// ===== rtl/core/rle_scale.sv =====
// Two-stage duty scaler for one channel: level * scale, then * 100 / 255.
// Depends on nothing outside this file.
module rle_scale (
  input  logic        clk,
  input  logic [7:0]  level,
  input  logic [7:0]  scale,
  input  logic        load_prod,
  input  logic        load_duty,
  output logic [14:0] duty
);

  // floor(p * 100 / 255) == (p * RECIP) >> SHIFT, exact for every 16-bit product.
  localparam int          SHIFT = 24;
  localparam logic [22:0] RECIP = 23'd6579301;

  logic [15:0] prod;
  logic [38:0] wide;

  assign wide = {23'd0, prod} * {16'd0, RECIP};

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod <= level * scale;
    end
    if (load_duty) begin
      duty <= wide[SHIFT +: 15];
    end
  end

endmodule

// ===== rtl/core/rgb_led_effect_engine.sv =====
// Top level of the RGB LED effect engine: handshake, pipeline control and
// three duty scalers. Depends on rle_pkg, rle_effect and rle_scale.
//
//   channel  direction  handshake               payload
//   tick     in         tick_valid/tick_stall   mic_active
//   duty     out        duty_valid/duty_stall   duty_red, duty_green, duty_blue
//   config   in         cfg_write               cfg_index, cfg_data
//
// One tick is taken every cycle while tick_stall is low; a tick that
// advances the effect passes to its duties through the three register
// stages: effect state, level product and scaling by 100/255.
// Reset is synchronous; tick_stall is high during it.
// A stalled output holds the pipeline, and tick_stall rises only once all
// three stages are full.
module rgb_led_effect_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic        mic_active,
  output logic        duty_valid,
  input  logic        duty_stall,
  output logic [14:0] duty_red,
  output logic [14:0] duty_green,
  output logic [14:0] duty_blue,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  rle_pkg::cfg_wr_t  cfg;
  rle_pkg::eff_out_t eff;

  logic       accept;
  logic       ready1, ready2, ready3;
  logic       s1_valid, s2_valid;
  logic [7:0] s1_red, s1_green, s1_blue, s1_scale;

  assign cfg    = '{en: cfg_write, index: cfg_index, data: cfg_data};
  assign ready3 = !duty_valid || !duty_stall;
  assign ready2 = !s2_valid || ready3;
  assign ready1 = !s1_valid || ready2;
  assign tick_stall = rst || !ready1;
  assign accept = tick_valid && !tick_stall;

  rle_effect u_effect (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (accept),
    .mic  (mic_active),
    .eff  (eff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      duty_valid <= 1'b0;
    end else begin
      if (ready1) s1_valid   <= accept && eff.emit;
      if (ready2) s2_valid   <= s1_valid;
      if (ready3) duty_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_red   <= eff.lvl_red;
      s1_green <= eff.lvl_green;
      s1_blue  <= eff.lvl_blue;
      s1_scale <= eff.scale;
    end
  end

  rle_scale u_scale_red (
    .clk       (clk),
    .level     (s1_red),
    .scale     (s1_scale),
    .load_prod (ready2),
    .load_duty (ready3),
    .duty      (duty_red)
  );

  rle_scale u_scale_green (
    .clk       (clk),
    .level     (s1_green),
    .scale     (s1_scale),
    .load_prod (ready2),
    .load_duty (ready3),
    .duty      (duty_green)
  );

  rle_scale u_scale_blue (
    .clk       (clk),
    .level     (s1_blue),
    .scale     (s1_scale),
    .load_prod (ready2),
    .load_duty (ready3),
    .duty      (duty_blue)
  );

endmodule

// ===== rtl/core/rle_check.sv =====
// Port-level checks for the RGB LED effect engine, bound to its top level.
// Depends only on the ports of rgb_led_effect_engine.
module rle_check (
  input logic        clk,
  input logic        rst,
  input logic        tick_valid,
  input logic        tick_stall,
  input logic        duty_valid,
  input logic        duty_stall,
  input logic [14:0] duty_red,
  input logic [14:0] duty_green,
  input logic [14:0] duty_blue
);

  // A stalled transaction keeps its duties.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    duty_valid && duty_stall |=> duty_valid && $stable(duty_red) &&
      $stable(duty_green) && $stable(duty_blue))
    else $error("stalled duty transaction changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> duty_red <= 15'd25500 && duty_green <= 15'd25500 &&
      duty_blue <= 15'd25500)
    else $error("duty above full scale");

  // With the output empty, nothing downstream can hold back a tick.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !duty_valid |-> !tick_stall)
    else $error("tick stalled with empty output");

  // A new result after an empty output traces back through the duty, product and level registers to an accepted tick.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(duty_valid) |-> $past(tick_valid && !tick_stall, 3))
    else $error("duty transaction without matching tick");

endmodule

bind rgb_led_effect_engine rle_check u_check (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick_valid),
  .tick_stall (tick_stall),
  .duty_valid (duty_valid),
  .duty_stall (duty_stall),
  .duty_red   (duty_red),
  .duty_green (duty_green),
  .duty_blue  (duty_blue)
);
